// ----- rtl/mirr_pkg.sv -----
// Package: shared constants, types and the CRC-16/MODBUS byte update.
`timescale 1ns / 1ps
package mirr_pkg;

    // input opcodes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // result kinds
    localparam logic KIND_TX   = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_TIMEOUT = 2'd1;
    localparam logic [1:0] ERR_CRC     = 2'd2;
    localparam logic [1:0] ERR_HEADER  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_DEV_ADDR  = 2'd0;
    localparam logic [1:0] CFG_START_REG = 2'd1;
    localparam logic [1:0] CFG_REG_COUNT = 2'd2;
    localparam logic [1:0] CFG_TIMEOUT   = 2'd3;

    localparam logic [7:0]  RST_DEV_ADDR  = 8'd1;
    localparam logic [15:0] RST_START_REG = 16'd1;
    localparam logic [15:0] RST_REG_COUNT = 16'd2;
    localparam logic [15:0] RST_TIMEOUT   = 16'd300;

    localparam logic [7:0]  FUNC_READ_INPUT  = 8'h04;
    localparam logic [7:0]  REPLY_BYTE_COUNT = 8'd4;
    localparam logic [15:0] CRC_INIT         = 16'hFFFF;
    localparam logic [15:0] CRC_POLY         = 16'hA001;
    localparam logic [15:0] TICKS_MAX        = 16'hFFFF;

    typedef struct packed {
        logic [7:0]  dev_addr;
        logic [15:0] start_reg;
        logic [15:0] reg_count;
        logic [15:0] timeout;
    } t_cfg;

    // one queue entry: either "send the request" or a finished transaction
    typedef struct packed {
        logic               is_done;
        logic               success;
        logic [1:0]         err;
        logic signed [15:0] temp;
        logic [15:0]        hum;
    } t_cmd;

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- rtl/mirr_in_if.sv -----
// Interface: input item channel (opcode and received byte).
`timescale 1ns / 1ps
interface mirr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] rx_byte;

    modport source (output valid, output opcode, output rx_byte, input ready);
    modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

// ----- rtl/mirr_out_if.sv -----
// Interface: result channel (transmit bytes and transaction status).
`timescale 1ns / 1ps
interface mirr_out_if;
    logic               valid;
    logic               ready;
    logic               result_kind;
    logic [7:0]         tx_byte;
    logic               last_of_run;
    logic               success;
    logic [1:0]         error_code;
    logic signed [15:0] temperature_tenths;
    logic [15:0]        humidity_tenths;

    modport source (output valid, output result_kind, output tx_byte, output last_of_run,
                    output success, output error_code, output temperature_tenths,
                    output humidity_tenths, input ready);
    modport sink   (input valid, input result_kind, input tx_byte, input last_of_run,
                    input success, input error_code, input temperature_tenths,
                    input humidity_tenths, output ready);
endinterface

// ----- rtl/mirr_front.sv -----
// Front end: accepts items, tracks the transaction and queues commands.
`timescale 1ns / 1ps
module mirr_front import mirr_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    mirr_in_if.sink i_item,
    input  t_cfg   i_cfg,
    input  logic   i_q_full,
    output logic   o_q_push,
    output t_cmd   o_q_cmd
);

    localparam logic [3:0] LAST_RX   = 4'd8;  // ninth reply byte closes the frame
    localparam logic [3:0] CRC_BYTES = 4'd7;

    logic        r_busy, n_busy;
    logic [3:0]  r_cnt, n_cnt;
    logic [15:0] r_crc, n_crc;
    logic [15:0] r_elapsed, n_elapsed;
    logic [7:0]  r_bytes [0:7];

    logic        w_acc;
    logic        w_store;
    logic [15:0] w_rx_crc;
    logic [15:0] w_el_inc;
    logic        w_hdr_ok;

    assign i_item.ready = !i_q_full;
    assign w_acc        = i_item.valid && i_item.ready;

    assign w_rx_crc = {i_item.rx_byte, r_bytes[7]};
    assign w_el_inc = (r_elapsed == TICKS_MAX) ? r_elapsed : r_elapsed + 16'd1;
    assign w_hdr_ok = (r_bytes[0] == i_cfg.dev_addr) && (r_bytes[1] == FUNC_READ_INPUT)
                   && (r_bytes[2] == REPLY_BYTE_COUNT);
    assign w_store  = w_acc && (i_item.opcode == OP_BYTE) && r_busy && (r_cnt != LAST_RX);

    always_comb begin
        n_busy    = r_busy;
        n_cnt     = r_cnt;
        n_crc     = r_crc;
        n_elapsed = r_elapsed;
        o_q_push  = 1'b0;
        o_q_cmd   = '0;
        if (w_acc) begin
            unique case (i_item.opcode)
                OP_START: begin
                    if (!r_busy) begin
                        o_q_push  = 1'b1;
                        n_busy    = 1'b1;
                        n_cnt     = '0;
                        n_crc     = CRC_INIT;
                        n_elapsed = '0;
                    end
                end
                OP_BYTE: begin
                    if (r_busy) begin
                        if (r_cnt == LAST_RX) begin
                            o_q_push        = 1'b1;
                            o_q_cmd.is_done = 1'b1;
                            n_busy          = 1'b0;
                            n_cnt           = r_cnt + 4'd1;
                            if (w_rx_crc != r_crc) begin
                                o_q_cmd.err = ERR_CRC;
                            end else if (!w_hdr_ok) begin
                                o_q_cmd.err = ERR_HEADER;
                            end else begin
                                o_q_cmd.success = 1'b1;
                                o_q_cmd.err     = ERR_NONE;
                                o_q_cmd.temp    = $signed({r_bytes[3], r_bytes[4]});
                                o_q_cmd.hum     = {r_bytes[5], r_bytes[6]};
                            end
                        end else begin
                            if (r_cnt < CRC_BYTES) begin
                                n_crc = crc_update(r_crc, i_item.rx_byte);
                            end
                            n_cnt = r_cnt + 4'd1;
                        end
                    end
                end
                OP_TICK: begin
                    if (r_busy) begin
                        n_elapsed = w_el_inc;
                        if (w_el_inc >= i_cfg.timeout) begin
                            o_q_push        = 1'b1;
                            o_q_cmd.is_done = 1'b1;
                            o_q_cmd.err     = ERR_TIMEOUT;
                            n_busy          = 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_cnt     <= '0;
            r_crc     <= CRC_INIT;
            r_elapsed <= '0;
        end else begin
            r_busy    <= n_busy;
            r_cnt     <= n_cnt;
            r_crc     <= n_crc;
            r_elapsed <= n_elapsed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_bytes[r_cnt[2:0]] <= i_item.rx_byte;
        end
    end

endmodule

// ----- rtl/mirr_fifo.sv -----
// Command queue between front end and back end.
`timescale 1ns / 1ps
module mirr_fifo import mirr_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd           r_mem [0:DEPTH-1];
    logic [AW-1:0]  r_wp, r_rp;
    logic [CW-1:0]  r_count;
    logic           w_push, w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (w_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

// ----- rtl/mirr_back.sv -----
// Back end: turns queued commands into result beats through an output register.
`timescale 1ns / 1ps
module mirr_back import mirr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_q_valid,
    input  t_cmd i_q_cmd,
    output logic o_q_pop,
    mirr_out_if.source o_rsp
);

    localparam logic [2:0] REQ_LAST      = 3'd7;
    localparam logic [2:0] REQ_CRC_BYTES = 3'd6;

    logic [2:0]         r_idx;
    logic [15:0]        r_crc;
    logic               r_valid;
    logic               r_kind;
    logic [7:0]         r_tx;
    logic               r_last;
    logic               r_success;
    logic [1:0]         r_err;
    logic signed [15:0] r_temp;
    logic [15:0]        r_hum;

    logic               w_load;
    logic [7:0]         w_byte;

    assign w_load  = i_q_valid && (!r_valid || o_rsp.ready);
    assign o_q_pop = w_load && (i_q_cmd.is_done || (r_idx == REQ_LAST));

    always_comb begin
        unique case (r_idx)
            3'd0:    w_byte = i_cfg.dev_addr;
            3'd1:    w_byte = FUNC_READ_INPUT;
            3'd2:    w_byte = i_cfg.start_reg[15:8];
            3'd3:    w_byte = i_cfg.start_reg[7:0];
            3'd4:    w_byte = i_cfg.reg_count[15:8];
            3'd5:    w_byte = i_cfg.reg_count[7:0];
            3'd6:    w_byte = r_crc[7:0];
            default: w_byte = r_crc[15:8];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_crc   <= CRC_INIT;
            r_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_valid <= 1'b0;
            end
            // request CRC is built one byte per beat as the bytes go out
            if (w_load && !i_q_cmd.is_done) begin
                r_idx <= r_idx + 3'd1;
                if (r_idx == REQ_LAST) begin
                    r_crc <= CRC_INIT;
                end else if (r_idx < REQ_CRC_BYTES) begin
                    r_crc <= crc_update(r_crc, w_byte);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (i_q_cmd.is_done) begin
                r_kind    <= KIND_DONE;
                r_tx      <= '0;
                r_last    <= 1'b0;
                r_success <= i_q_cmd.success;
                r_err     <= i_q_cmd.err;
                r_temp    <= i_q_cmd.temp;
                r_hum     <= i_q_cmd.hum;
            end else begin
                r_kind    <= KIND_TX;
                r_tx      <= w_byte;
                r_last    <= (r_idx == REQ_LAST);
                r_success <= 1'b0;
                r_err     <= ERR_NONE;
                r_temp    <= '0;
                r_hum     <= '0;
            end
        end
    end

    assign o_rsp.valid              = r_valid;
    assign o_rsp.result_kind        = r_kind;
    assign o_rsp.tx_byte            = r_tx;
    assign o_rsp.last_of_run        = r_last;
    assign o_rsp.success            = r_success;
    assign o_rsp.error_code         = r_err;
    assign o_rsp.temperature_tenths = r_temp;
    assign o_rsp.humidity_tenths    = r_hum;

endmodule

// ----- rtl/modbus_input_register_reader_unit.sv -----
// Top level: Modbus RTU read-input-registers master with config registers.
//
// Input channel i_item carries one opcode per beat: start, received byte or
// millisecond tick. Output channel o_rsp carries result beats: eight transmit
// bytes per request (last_of_run on the eighth, CRC low byte then high byte)
// and one done beat per transaction with success, error code and, on
// success, raw temperature and humidity in tenths.
// Config: i_cfg_we writes i_cfg_wdata into register i_cfg_idx
// (0 device address, 1 start register, 2 register count, 3 timeout ticks).
// A result passes through the command queue, written at the accepting edge,
// then the output register, loaded when it is empty or its beat is taken.
// Throughput: one item per cycle on the input side while the queue is not
// full; one beat per cycle on the output side while the receiver is ready.
// The request CRC is formed one byte per beat in the back end, the reply
// CRC one byte per item in the front end.
// When the receiver stalls, the output register holds its beat, the queue
// of P_QDEPTH commands fills, and i_item.ready drops only when it is full.
// Synchronous reset returns to idle, empties the queue and loads default
// config (address 1, start 1, count 2, timeout 300).
`timescale 1ns / 1ps
module modbus_input_register_reader_unit import mirr_pkg::*; #(
    parameter int P_QDEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mirr_in_if.sink     i_item,
    mirr_out_if.source  o_rsp,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata
);

    t_cfg r_cfg;
    logic w_q_full, w_q_push, w_q_pop, w_q_valid;
    t_cmd w_push_cmd, w_head_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dev_addr  <= RST_DEV_ADDR;
            r_cfg.start_reg <= RST_START_REG;
            r_cfg.reg_count <= RST_REG_COUNT;
            r_cfg.timeout   <= RST_TIMEOUT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DEV_ADDR:  r_cfg.dev_addr  <= i_cfg_wdata[7:0];
                CFG_START_REG: r_cfg.start_reg <= i_cfg_wdata;
                CFG_REG_COUNT: r_cfg.reg_count <= i_cfg_wdata;
                CFG_TIMEOUT:   r_cfg.timeout   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    mirr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cfg    (r_cfg),
        .i_q_full (w_q_full),
        .o_q_push (w_q_push),
        .o_q_cmd  (w_push_cmd)
    );

    mirr_fifo #(.DEPTH(P_QDEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_q_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_head_cmd)
    );

    mirr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (w_q_valid),
        .i_q_cmd   (w_head_cmd),
        .o_q_pop   (w_q_pop),
        .o_rsp     (o_rsp)
    );

endmodule

// ----- rtl/mirr_chk.sv -----
// Checker: port-level assertions on the result channel, bound to the top level.
`timescale 1ns / 1ps
module mirr_chk import mirr_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               i_ready,
    input logic               i_kind,
    input logic [7:0]         i_tx,
    input logic               i_last,
    input logic               i_success,
    input logic [1:0]         i_err,
    input logic signed [15:0] i_temp,
    input logic [15:0]        i_hum
);

    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("result beat right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_kind) && $stable(i_tx)
            && $stable(i_last) && $stable(i_err))
        else $error("stalled result beat changed");

    a_last_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_last |-> i_kind == KIND_TX)
        else $error("last_of_run on a done beat");

    a_done_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind == KIND_DONE |-> i_success == (i_err == ERR_NONE))
        else $error("success flag disagrees with error code");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_success |-> i_temp == 16'sd0 && i_hum == 16'd0)
        else $error("data on a beat without success");

endmodule

bind modbus_input_register_reader_unit mirr_chk u_mirr_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (o_rsp.valid),
    .i_ready   (o_rsp.ready),
    .i_kind    (o_rsp.result_kind),
    .i_tx      (o_rsp.tx_byte),
    .i_last    (o_rsp.last_of_run),
    .i_success (o_rsp.success),
    .i_err     (o_rsp.error_code),
    .i_temp    (o_rsp.temperature_tenths),
    .i_hum     (o_rsp.humidity_tenths)
);

// ----- tb/modbus_input_register_reader_unit_test.sv -----
// Testbench: Modbus read-input-registers master, table-driven and random stimulus.
`timescale 1ns / 1ps
module modbus_input_register_reader_unit_test;
    import mirr_pkg::*;

    localparam logic [1:0]  OP_UNUSED     = 2'd3;
    localparam int          REPLY_LEN     = 9;
    localparam int          REPLY_CRC_LEN = 7;
    localparam int          RANDOM_ITEMS  = 450;
    localparam int          PHASE_ITEMS   = 75;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          SETTLE_CYCLES = 10;
    // request for the default config: addr 1, fn 4, start 1, count 2, CRC 0x0B20
    localparam logic [63:0] RESET_REQUEST = 64'h01_04_00_01_00_02_20_0B;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        logic               kind;
        logic [7:0]         tx;
        logic               last;
        logic               ok;
        logic [1:0]         err;
        logic signed [15:0] temp;
        logic [15:0]        hum;
    } t_beat;

    // where a table row takes its data byte from
    typedef enum logic [1:0] {
        SRC_LIT,
        SRC_CRC_LO,
        SRC_CRC_HI,
        SRC_CRC_BAD
    } t_byte_src;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  data;
        t_byte_src   src;
        logic        given;
        logic        ok;
        logic [1:0]  err;
        logic [15:0] temp;
        logic [15:0] hum;
    } t_plan;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [15:0] cfg_wdata;

    mirr_in_if  item_if ();
    mirr_out_if rsp_if ();

    modbus_input_register_reader_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_if),
        .o_rsp       (rsp_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    // master state mirror
    t_cfg        regs;
    logic        busy;
    logic [3:0]  rx_cnt;
    logic [15:0] rx_crc;
    logic [7:0]  rx_buf [0:8];
    logic [15:0] tick_cnt;

    t_beat step_beats [$];
    t_beat beats_due [$];
    t_plan plan [$];

    int    send_idle_pct;
    int    recv_idle_pct;
    int    active_items;
    int    mismatches;
    int    beat_no;
    int    hold_left;
    bit    hold_used;
    t_beat want_beat;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("timeout: %0d beats still due", beats_due.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [15:0] crc16_mb(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        r = acc ^ {8'h00, b};
        repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        return r;
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [15:0] extreme_word();
        case ($urandom_range(0, 3))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic void close_txn(input logic ok, input logic [1:0] err,
                                      input logic [15:0] t, input logic [15:0] h);
        t_beat b;
        b      = '0;
        b.kind = KIND_DONE;
        b.ok   = ok;
        b.err  = err;
        b.temp = t;
        b.hum  = h;
        step_beats.push_back(b);
        busy = 1'b0;
    endfunction

    // one input item through the master; returns 1 unless the item is dropped
    function automatic bit reader_step(input t_item it);
        logic [7:0]  req [0:7];
        logic [15:0] c;
        t_beat       b;
        step_beats.delete();
        if (it.op == OP_START) begin
            if (busy) return 1'b0;
            req[0] = regs.dev_addr;
            req[1] = FUNC_READ_INPUT;
            req[2] = regs.start_reg[15:8];
            req[3] = regs.start_reg[7:0];
            req[4] = regs.reg_count[15:8];
            req[5] = regs.reg_count[7:0];
            c = CRC_INIT;
            for (int i = 0; i < 6; i++) c = crc16_mb(c, req[i]);
            req[6] = c[7:0];
            req[7] = c[15:8];
            for (int i = 0; i < 8; i++) begin
                b      = '0;
                b.kind = KIND_TX;
                b.tx   = req[i];
                b.last = (i == 7);
                step_beats.push_back(b);
            end
            busy     = 1'b1;
            rx_cnt   = '0;
            rx_crc   = CRC_INIT;
            tick_cnt = '0;
            return 1'b1;
        end
        if (it.op == OP_BYTE) begin
            if (!busy) return 1'b0;
            if (rx_cnt < REPLY_LEN) begin
                rx_buf[rx_cnt] = it.data;
                if (rx_cnt < REPLY_CRC_LEN) rx_crc = crc16_mb(rx_crc, it.data);
                rx_cnt++;
            end
            if (rx_cnt >= REPLY_LEN) begin
                // CRC is judged before the header
                if ({rx_buf[8], rx_buf[7]} != rx_crc) begin
                    close_txn(1'b0, ERR_CRC, '0, '0);
                end else if (rx_buf[0] != regs.dev_addr || rx_buf[1] != FUNC_READ_INPUT ||
                             rx_buf[2] != REPLY_BYTE_COUNT) begin
                    close_txn(1'b0, ERR_HEADER, '0, '0);
                end else begin
                    close_txn(1'b1, ERR_NONE, {rx_buf[3], rx_buf[4]}, {rx_buf[5], rx_buf[6]});
                end
            end
            return 1'b1;
        end
        if (it.op == OP_TICK) begin
            if (!busy) return 1'b0;
            if (tick_cnt != TICKS_MAX) tick_cnt++;
            if (tick_cnt >= regs.timeout) close_txn(1'b0, ERR_TIMEOUT, '0, '0);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        $display("%0t ns beat %0d: %s", $time, beat_no, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_item(input t_item it, input bit keep);
        bit act;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            item_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_if.valid   <= 1'b1;
        item_if.opcode  <= it.op;
        item_if.rx_byte <= it.data;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        act = reader_step(it);
        if (act) active_items++;
        if (keep) foreach (step_beats[i]) beats_due.push_back(step_beats[i]);
        @(negedge i_clk);
    endtask

    task automatic plan_row(input logic [1:0] op, input logic [7:0] data, input t_byte_src src,
                            input logic given, input logic ok, input logic [1:0] err,
                            input logic [15:0] temp, input logic [15:0] hum);
        plan.push_back({op, data, src, given, ok, err, temp, hum});
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(negedge i_clk);
        case (idx)
            CFG_DEV_ADDR:  regs.dev_addr  = val[7:0];
            CFG_START_REG: regs.start_reg = val;
            CFG_REG_COUNT: regs.reg_count = val;
            default:       regs.timeout   = val;
        endcase
    endtask

    // finish any open transaction, then wait for the output side to drain
    task automatic quiesce();
        while (busy) send_item({OP_BYTE, rand_byte()}, 1'b1);
        item_if.valid <= 1'b0;
        while (beats_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // one request plus a reply that is mostly well formed
    task automatic run_exchange();
        logic [7:0]  rep [0:8];
        logic [15:0] c;
        logic [7:0]  flip;
        int          style;
        int          nbytes;
        int          ticks;
        int          k;
        send_item({OP_START, rand_byte()}, 1'b1);
        style  = $urandom_range(0, 99);
        rep[0] = regs.dev_addr;
        rep[1] = FUNC_READ_INPUT;
        rep[2] = REPLY_BYTE_COUNT;
        for (int i = 3; i < REPLY_CRC_LEN; i++) rep[i] = rand_byte();
        if ($urandom_range(0, 4) == 0) begin
            {rep[3], rep[4]} = extreme_word();
            {rep[5], rep[6]} = extreme_word();
        end
        flip = 8'($urandom_range(1, 255));
        if (style >= 55 && style < 70) begin
            k = $urandom_range(0, 2);
            rep[k] = rep[k] ^ flip;
        end
        c = CRC_INIT;
        for (int i = 0; i < REPLY_CRC_LEN; i++) c = crc16_mb(c, rep[i]);
        rep[7] = c[7:0];
        rep[8] = c[15:8];
        if (style >= 70 && style < 82) begin
            k = $urandom_range(3, 8);
            rep[k] = rep[k] ^ flip;
        end
        if (style >= 82 && style < 92) begin
            ticks = $urandom_range(1, 20);
            while (busy && ticks > 0) begin
                send_item({OP_TICK, rand_byte()}, 1'b1);
                ticks--;
            end
        end
        nbytes = (style >= 92) ? $urandom_range(0, 12) : REPLY_LEN;
        for (int i = 0; i < nbytes; i++) begin
            if ($urandom_range(0, 99) < 8) begin
                case ($urandom_range(0, 2))
                    0: send_item({OP_TICK, rand_byte()}, 1'b1);
                    1: send_item({OP_UNUSED, rand_byte()}, 1'b1);
                    default: send_item({OP_START, rand_byte()}, 1'b1);
                endcase
            end
            send_item({OP_BYTE, (i < REPLY_LEN) ? rep[i] : rand_byte()}, 1'b1);
        end
    endtask

    // response side: random back-pressure plus one long hold-off
    initial begin
        rsp_if.ready = 1'b0;
        hold_left    = 0;
        hold_used    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_used && i_rst_n && send_idle_pct == 0 && recv_idle_pct == 0) begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            beat_no++;
            if (beats_due.size() == 0) begin
                flag_mismatch("beat with nothing due");
            end else begin
                want_beat = beats_due.pop_front();
                check_field("result_kind", 16'(rsp_if.result_kind), 16'(want_beat.kind));
                check_field("tx_byte", 16'(rsp_if.tx_byte), 16'(want_beat.tx));
                check_field("last_of_run", 16'(rsp_if.last_of_run), 16'(want_beat.last));
                check_field("success", 16'(rsp_if.success), 16'(want_beat.ok));
                check_field("error_code", 16'(rsp_if.error_code), 16'(want_beat.err));
                check_field("temperature_tenths", rsp_if.temperature_tenths, want_beat.temp);
                check_field("humidity_tenths", rsp_if.humidity_tenths, want_beat.hum);
            end
        end
    end

    initial begin
        t_plan       row;
        logic [7:0]  d;
        t_beat       b;
        t_cfg        c;
        int          phase_no;
        int          goal;

        item_if.valid   = 1'b0;
        item_if.opcode  = OP_START;
        item_if.rx_byte = 8'h00;
        cfg_we          = 1'b0;
        cfg_idx         = CFG_DEV_ADDR;
        cfg_wdata       = 16'h0000;
        i_rst_n         = 1'b0;
        regs            = {RST_DEV_ADDR, RST_START_REG, RST_REG_COUNT, RST_TIMEOUT};
        busy            = 1'b0;
        rx_cnt          = '0;
        rx_crc          = CRC_INIT;
        tick_cnt        = '0;
        mismatches      = 0;
        beat_no         = 0;
        active_items    = 0;
        send_idle_pct   = 16;
        recv_idle_pct   = 85;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // dropped while idle, then the default request and a start dropped while busy
        plan_row(OP_TICK,   8'h00, SRC_LIT, 1'b0, 1'b0, ERR_NONE, '0, '0);
        plan_row(OP_BYTE,   8'hFF, SRC_LIT, 1'b0, 1'b0, ERR_NONE, '0, '0);
        plan_row(OP_UNUSED, 8'hA5, SRC_LIT, 1'b0, 1'b0, ERR_NONE, '0, '0);
        plan_row(OP_START,  8'h00, SRC_LIT, 1'b1, 1'b0, ERR_NONE, '0, '0);
        plan_row(OP_START,  8'h5A, SRC_LIT, 1'b0, 1'b0, ERR_NONE, '0, '0);
        // good reply, most negative temperature and full-scale humidity
        plan_row(OP_BYTE,   8'h01, SRC_LIT, 1'b0, 1'b0, ERR_NONE, '0, '0);
        plan_row(OP_BYTE,   8'h04, SRC_LIT, 1'b0, 1'b0, ERR_NONE, '0, '0);
        plan_row(OP_BYTE,   8'h04, SRC_LIT, 1'b0, 1'b0, ERR_NONE, '0, '0);
        plan_row(OP_BYTE,   8'h80, SRC_LIT, 1'b0, 1'b0, ERR_NONE, '0, '0);
        plan_row(OP_BYTE,   8'h00, SRC_LIT, 1'b0, 1'b0, ERR_NONE, '0, '0);
        plan_row(OP_BYTE,   8'hFF, SRC_LIT, 1'b0, 1'b0, ERR_NONE, '0, '0);
        plan_row(OP_BYTE,   8'hFF, SRC_LIT, 1'b0, 1'b0, ERR_NONE, '0, '0);
        plan_row(OP_BYTE,   8'h00, SRC_CRC_LO, 1'b0, 1'b0, ERR_NONE, '0, '0);
        plan_row(OP_BYTE,   8'h00, SRC_CRC_HI, 1'b1, 1'b1, ERR_NONE, 16'h8000, 16'hFFFF);
        // bad header and bad CRC: CRC wins
        plan_row(OP_START,  8'h00, SRC_LIT, 1'b0, 1'b0, ERR_NONE, '0, '0);
        plan_row(OP_TICK,   8'hFF, SRC_LIT, 1'b0, 1'b0, ERR_NONE, '0, '0);
        plan_row(OP_BYTE,   8'h02, SRC_LIT, 1'b0, 1'b0, ERR_NONE, '0, '0);
        plan_row(OP_BYTE,   8'h03, SRC_LIT, 1'b0, 1'b0, ERR_NONE, '0, '0);
        plan_row(OP_BYTE,   8'h05, SRC_LIT, 1'b0, 1'b0, ERR_NONE, '0, '0);
        plan_row(OP_BYTE,   8'h7F, SRC_LIT, 1'b0, 1'b0, ERR_NONE, '0, '0);
        plan_row(OP_BYTE,   8'hFF, SRC_LIT, 1'b0, 1'b0, ERR_NONE, '0, '0);
        plan_row(OP_BYTE,   8'h00, SRC_LIT, 1'b0, 1'b0, ERR_NONE, '0, '0);
        plan_row(OP_BYTE,   8'h00, SRC_LIT, 1'b0, 1'b0, ERR_NONE, '0, '0);
        plan_row(OP_BYTE,   8'h00, SRC_CRC_LO, 1'b0, 1'b0, ERR_NONE, '0, '0);
        plan_row(OP_BYTE,   8'h00, SRC_CRC_BAD, 1'b1, 1'b0, ERR_CRC, '0, '0);

        foreach (plan[n]) begin
            row = plan[n];
            case (row.src)
                SRC_LIT:    d = row.data;
                SRC_CRC_LO: d = rx_crc[7:0];
                SRC_CRC_HI: d = rx_crc[15:8];
                default:    d = ~rx_crc[15:8];
            endcase
            send_item({row.op, d}, !row.given);
            if (row.given && row.op == OP_START) begin
                for (int i = 0; i < 8; i++) begin
                    b      = '0;
                    b.kind = KIND_TX;
                    b.tx   = RESET_REQUEST[63 - 8 * i -: 8];
                    b.last = (i == 7);
                    beats_due.push_back(b);
                end
            end else if (row.given) begin
                b      = '0;
                b.kind = KIND_DONE;
                b.ok   = row.ok;
                b.err  = row.err;
                b.temp = row.temp;
                b.hum  = row.hum;
                beats_due.push_back(b);
            end
        end
        quiesce();

        active_items = 0;
        phase_no     = 0;
        while (active_items < RANDOM_ITEMS) begin
            c.dev_addr  = rand_byte();
            c.start_reg = 16'($urandom_range(0, 65535));
            c.reg_count = 16'($urandom_range(0, 65535));
            case (phase_no % 5)
                0: c = '0;                    // zero timeout ends on the first tick
                1: c = '1;
                2: c.timeout = 16'($urandom_range(1, 6));
                3: c.timeout = 16'($urandom_range(10, 80));
                default: c = {c.dev_addr, RST_START_REG, RST_REG_COUNT, RST_TIMEOUT};
            endcase
            write_reg(CFG_DEV_ADDR, {rand_byte(), c.dev_addr});
            write_reg(CFG_START_REG, c.start_reg);
            write_reg(CFG_REG_COUNT, c.reg_count);
            write_reg(CFG_TIMEOUT, c.timeout);
            cfg_we <= 1'b0;

            goal = active_items + PHASE_ITEMS;
            while (active_items < goal && active_items < RANDOM_ITEMS) begin
                if (active_items < RANDOM_ITEMS / 3) begin
                    send_idle_pct = 16;
                    recv_idle_pct = 85;
                end else if (active_items < 2 * RANDOM_ITEMS / 3) begin
                    send_idle_pct = 85;
                    recv_idle_pct = 16;
                end else begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                run_exchange();
            end
            quiesce();
            phase_no++;
        end

        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/mirr_pkg.sv
rtl/mirr_in_if.sv
rtl/mirr_out_if.sv
rtl/mirr_front.sv
rtl/mirr_fifo.sv
rtl/mirr_back.sv
rtl/modbus_input_register_reader_unit.sv
rtl/mirr_chk.sv
tb/modbus_input_register_reader_unit_test.sv
